FILE: hdl/lsort_pkg.sv
package lsort_pkg;

  localparam int VAL_W = 32;
  localparam int IDX_W = 6;

  // configuration register byte addresses
  localparam logic [2:0] ADDR_DESCENDING = 3'd0;

  // command codes
  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_REPEAT = 1'b1;

  typedef struct packed {
    logic                    command;
    logic signed [VAL_W-1:0] value;
    logic                    last_in;
  } item_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] sorted_value;
    logic [IDX_W-1:0]        original_index;
    logic                    last_out;
  } result_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic [IDX_W-1:0]        index;
  } entry_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FETCH,
    ST_KEY,
    ST_SCAN,
    ST_PLACE,
    ST_REV_A,
    ST_REV_B,
    ST_REV_C,
    ST_REV_D,
    ST_EMIT
  } state_t;

  // true when entry a must come before entry b
  function automatic logic goes_before(entry_t a, entry_t b, logic desc);
    logic res;
    if (a.value != b.value) begin
      res = desc ? (a.value > b.value) : (a.value < b.value);
    end else begin
      res = a.index < b.index;
    end
    return res;
  endfunction

endpackage

FILE: hdl/lsort_ram.sv
module lsort_ram #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  lsort_pkg::entry_t wr_data,
  input  logic [AW-1:0]    rd_addr,
  output lsort_pkg::entry_t rd_data
);
  import lsort_pkg::*;

  entry_t mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: hdl/list_sort_with_index.sv
// list elements load one at a time while idle; the last element starts an
// insertion sort over the store memory, one shift per cycle on the single
// read port. results stream one per cycle afterwards; a repeat with a
// direction change first reverses the list, swapping each pair through the
// states REV_A to REV_D. one item at a time.
// synchronous reset clears counts and direction; the store holds no reset.
module list_sort_with_index #(
  parameter int MAX_ITEMS = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  lsort_pkg::item_t   item,
  output logic               result_valid,
  output lsort_pkg::result_t result,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import lsort_pkg::*;

  localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam logic [CW-1:0] CAP = CW'(MAX_ITEMS);

  state_t state, state_next;
  logic [CW-1:0] load_count, load_count_next;
  logic [CW-1:0] sorted_count, sorted_count_next;
  logic          sorted_dir, sorted_dir_next;
  logic          descending;
  logic [CW-1:0] i_cnt, i_cnt_next;
  logic [CW-1:0] j_cnt, j_cnt_next;
  entry_t        key, key_next;
  entry_t        hold, hold_next;
  logic          emit_pend, emit_pend_next;
  logic          emit_last, emit_last_next;

  logic          wr_en;
  logic [AW-1:0] wr_addr, rd_addr;
  entry_t        wr_data, rd_data;

  logic          accept, load_ok, repeat_ok, key_first;
  logic [CW-1:0] count_new;

  lsort_ram #(.DEPTH(MAX_ITEMS), .AW(AW)) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  assign busy      = (state != ST_IDLE);
  assign accept    = start && !busy;
  assign load_ok   = load_count < CAP;
  assign count_new = load_ok ? load_count + 1'b1 : load_count;
  assign repeat_ok = (load_count == '0) && (sorted_count != '0);
  assign key_first = goes_before(key, rd_data, sorted_dir);

  // configuration port
  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_DESCENDING) ? {31'd0, descending} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      descending <= 1'b0;
    end else if (psel && penable && pwrite && paddr == ADDR_DESCENDING) begin
      descending <= pwdata[0];
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (item.command == CMD_LOAD) begin
            if (item.last_in) begin
              state_next = (count_new > CW'(1)) ? ST_FETCH : ST_EMIT;
            end
          end else if (repeat_ok) begin
            state_next = (sorted_dir != descending && sorted_count > CW'(1)) ?
                         ST_REV_A : ST_EMIT;
          end
        end
      end
      ST_FETCH: state_next = ST_KEY;
      ST_KEY:   state_next = ST_SCAN;
      ST_SCAN: begin
        if (key_first) begin
          if (j_cnt == CW'(1)) begin
            state_next = ST_PLACE;
          end
        end else begin
          state_next = (i_cnt + 1'b1 == sorted_count) ? ST_EMIT : ST_FETCH;
        end
      end
      ST_PLACE: state_next = (i_cnt + 1'b1 == sorted_count) ? ST_EMIT : ST_FETCH;
      ST_REV_A: state_next = ST_REV_B;
      ST_REV_B: state_next = ST_REV_C;
      ST_REV_C: state_next = ST_REV_D;
      ST_REV_D: state_next = (i_cnt + 1'b1 < j_cnt - 1'b1) ? ST_REV_A : ST_EMIT;
      ST_EMIT: begin
        if (j_cnt >= sorted_count || j_cnt + 1'b1 == sorted_count) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    load_count_next   = load_count;
    sorted_count_next = sorted_count;
    sorted_dir_next   = sorted_dir;
    i_cnt_next        = i_cnt;
    j_cnt_next        = j_cnt;
    key_next          = key;
    hold_next         = hold;
    emit_pend_next    = 1'b0;
    emit_last_next    = 1'b0;
    wr_en             = 1'b0;
    wr_addr           = load_count[AW-1:0];
    wr_data           = '{value: item.value, index: IDX_W'(load_count)};
    rd_addr           = i_cnt[AW-1:0];
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (item.command == CMD_LOAD) begin
            wr_en           = load_ok;
            load_count_next = count_new;
            if (item.last_in) begin
              sorted_count_next = count_new;
              load_count_next   = '0;
              sorted_dir_next   = descending;
              i_cnt_next        = CW'(1);
              j_cnt_next        = '0;
            end
          end else if (repeat_ok) begin
            sorted_dir_next = descending;
            i_cnt_next      = '0;
            j_cnt_next      = (sorted_dir != descending && sorted_count > CW'(1)) ?
                              sorted_count - 1'b1 : '0;
          end
        end
      end
      ST_FETCH: rd_addr = i_cnt[AW-1:0];
      ST_KEY: begin
        key_next   = rd_data;
        j_cnt_next = i_cnt;
        rd_addr    = AW'(i_cnt - 1'b1);
      end
      // shift up the entries that the key goes before until the key finds its place
      ST_SCAN: begin
        wr_en   = 1'b1;
        wr_addr = j_cnt[AW-1:0];
        rd_addr = AW'(j_cnt - CW'(2));
        if (key_first) begin
          wr_data    = rd_data;
          j_cnt_next = j_cnt - 1'b1;
        end else begin
          wr_data    = key;
          i_cnt_next = i_cnt + 1'b1;
          j_cnt_next = '0;
        end
      end
      ST_PLACE: begin
        wr_en      = 1'b1;
        wr_addr    = j_cnt[AW-1:0];
        wr_data    = key;
        i_cnt_next = i_cnt + 1'b1;
        j_cnt_next = '0;
      end
      // swap entries i and j
      ST_REV_A: rd_addr = i_cnt[AW-1:0];
      ST_REV_B: begin
        hold_next = rd_data;
        rd_addr   = j_cnt[AW-1:0];
      end
      ST_REV_C: begin
        wr_en   = 1'b1;
        wr_addr = i_cnt[AW-1:0];
        wr_data = rd_data;
      end
      ST_REV_D: begin
        wr_en      = 1'b1;
        wr_addr    = j_cnt[AW-1:0];
        wr_data    = hold;
        i_cnt_next = i_cnt + 1'b1;
        j_cnt_next = (i_cnt + 1'b1 < j_cnt - 1'b1) ? j_cnt - 1'b1 : '0;
      end
      // stream the stored list out
      ST_EMIT: begin
        rd_addr = j_cnt[AW-1:0];
        if (j_cnt < sorted_count) begin
          emit_pend_next = 1'b1;
          emit_last_next = (j_cnt + 1'b1 == sorted_count);
          j_cnt_next     = j_cnt + 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      load_count   <= '0;
      sorted_count <= '0;
      sorted_dir   <= 1'b0;
      emit_pend    <= 1'b0;
    end else begin
      state        <= state_next;
      load_count   <= load_count_next;
      sorted_count <= sorted_count_next;
      sorted_dir   <= sorted_dir_next;
      emit_pend    <= emit_pend_next;
    end
    i_cnt     <= i_cnt_next;
    j_cnt     <= j_cnt_next;
    key       <= key_next;
    hold      <= hold_next;
    emit_last <= emit_last_next;
  end

  // result item follows the registered memory read
  assign result_valid          = emit_pend;
  assign result.sorted_value   = rd_data.value;
  assign result.original_index = rd_data.index;
  assign result.last_out       = emit_last;

  // checks
  a_cap: assert property (@(posedge clk) disable iff (rst) load_count <= CAP)
    else $error("load count beyond capacity");
  a_valid_src: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(state) == ST_EMIT)
    else $error("result item outside emit");
  a_last_gap: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.last_out |=> !result_valid)
    else $error("result after last item");
  a_bad_repeat: assert property (@(posedge clk) disable iff (rst)
    accept && item.command == CMD_REPEAT && !repeat_ok |=> !busy && !result_valid)
    else $error("repeat without stored list started work");

endmodule
